[rtl/hes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_pkg
// shared types, constants and bit-placement functions for the hamming block
// ----------------------------------------------------------------------------
package hes_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int CW_BITS       = 63;
  localparam int LEN_W         = 6;

  localparam logic [CW_BITS-1:0] CW_ONES = {CW_BITS{1'b1}};

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_CHECK  = 1'b1
  } cmd_t;

  // derived per-length settings, held while the block runs
  typedef struct packed {
    logic [LEN_W-1:0]   n;          // codeword length
    logic [CW_BITS-1:0] data_mask;  // data bits in use
    logic [CW_BITS-1:0] pos_mask;   // codeword positions 1..n
  } cfg_t;

  // smallest r with 2^r >= len + r + 1
  function automatic logic [2:0] parity_count(input logic [LEN_W-1:0] len);
    logic [2:0] r;
    r = 3'd6;
    for (int i = 6; i >= 0; i--) begin
      if ((8'd1 << i) >= (8'(len) + 8'(i) + 8'd1)) r = 3'(i);
    end
    return r;
  endfunction

  function automatic cfg_t derive_cfg(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    cfg_t c;
    len = raw;
    if (raw == '0) len = LEN_W'(1);
    if (raw > LEN_W'(MAX_DATA_BITS)) len = LEN_W'(MAX_DATA_BITS);
    c.n         = len + LEN_W'(parity_count(len));
    c.data_mask = ~(CW_ONES << len);
    c.pos_mask  = ~(CW_ONES << c.n);
    return c;
  endfunction

  // data bits, lowest first, onto the non-power-of-two positions
  function automatic logic [CW_BITS-1:0] scatter(input logic [CW_BITS-1:0] data);
    logic [CW_BITS-1:0] cw;
    logic [LEN_W-1:0]   k;
    cw = '0;
    k  = '0;
    for (int pos = 1; pos <= CW_BITS; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        cw[pos-1] = data[k];
        k = k + LEN_W'(1);
      end
    end
    return cw;
  endfunction

  // positions whose number has bit b set
  function automatic logic [CW_BITS-1:0] col_mask(input int b);
    logic [CW_BITS-1:0] m;
    m = '0;
    for (int pos = 1; pos <= CW_BITS; pos++) begin
      m[pos-1] = ((pos >> b) & 1) != 0;
    end
    return m;
  endfunction

  function automatic logic [LEN_W-1:0] syndrome_of(input logic [CW_BITS-1:0] cw);
    logic [LEN_W-1:0] s;
    for (int b = 0; b < LEN_W; b++) begin
      s[b] = ^(cw & col_mask(b));
    end
    return s;
  endfunction

endpackage

[rtl/hes_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_cfg
// data length register, kept as derived length and masks
// ----------------------------------------------------------------------------
module hes_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [hes_pkg::LEN_W-1:0] wr_data,
  output hes_pkg::cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= hes_pkg::derive_cfg(hes_pkg::LEN_W'(hes_pkg::MAX_DATA_BITS));
    end else if (wr_en) begin
      cfg <= hes_pkg::derive_cfg(wr_data);
    end
  end

endmodule

[rtl/hes_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_core
// encode and syndrome xor trees for one word
// ----------------------------------------------------------------------------
module hes_core (
  input  hes_pkg::cmd_t                  command,
  input  logic [hes_pkg::CW_BITS-1:0]    word,
  input  hes_pkg::cfg_t                  cfg,
  output logic [hes_pkg::CW_BITS-1:0]    codeword,
  output logic [hes_pkg::LEN_W-1:0]      syndrome,
  output logic                           error_found
);

  logic [hes_pkg::CW_BITS-1:0] enc_data;
  logic [hes_pkg::LEN_W-1:0]   enc_par;
  logic [hes_pkg::CW_BITS-1:0] enc_cw;
  logic [hes_pkg::LEN_W-1:0]   chk_syn;

  always_comb begin
    enc_data = hes_pkg::scatter(word & cfg.data_mask);
    enc_par  = hes_pkg::syndrome_of(enc_data);
    enc_cw   = enc_data;
    // parity at position 2^k
    for (int k = 0; k < hes_pkg::LEN_W; k++) begin
      enc_cw[(1 << k) - 1] = enc_par[k];
    end
    chk_syn = hes_pkg::syndrome_of(word & cfg.pos_mask);
  end

  always_comb begin
    case (command)
      hes_pkg::CMD_ENCODE: begin
        codeword    = enc_cw;
        syndrome    = '0;
        error_found = 1'b0;
      end
      hes_pkg::CMD_CHECK: begin
        codeword    = '0;
        syndrome    = chk_syn;
        error_found = chk_syn != '0;
      end
      default: begin
        codeword    = '0;
        syndrome    = '0;
        error_found = 1'b0;
      end
    endcase
  end

endmodule

[rtl/hamming_encode_and_syndrome.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_encode_and_syndrome
// even-parity hamming encoder and syndrome checker, length set by register
// ----------------------------------------------------------------------------
// channel   handshake             payload
// command   start / busy          command, word
// config    cfg_valid / cfg_ready cfg_data (data length)
// result    done (strobe)         codeword, codeword_length, syndrome,
//                                 error_found
//
// one beat accepted per cycle while busy is low; done and the result are
// registered: the beat goes into the input register, then through the xor
// trees into the result register, and done rises with the result beat
// rst is synchronous; busy is set in reset and cleared at the next edge
// with rst low, blocking cfg_ready with it; then busy is low for good
// the receiver cannot stall: done marks every result for one cycle only
// ----------------------------------------------------------------------------
module hamming_encode_and_syndrome (
  input  logic                        clk,
  input  logic                        rst,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [hes_pkg::CW_BITS-1:0] word,
  // config channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hes_pkg::LEN_W-1:0]   cfg_data,
  // result channel
  output logic                        done,
  output logic [hes_pkg::CW_BITS-1:0] codeword,
  output logic [hes_pkg::LEN_W-1:0]   codeword_length,
  output logic [hes_pkg::LEN_W-1:0]   syndrome,
  output logic                        error_found
);

  hes_pkg::cfg_t               cfg;
  logic                        accept;

  // input register
  logic                        in_valid;
  hes_pkg::cmd_t               in_cmd;
  logic [hes_pkg::CW_BITS-1:0] in_word;

  // core outputs
  logic [hes_pkg::CW_BITS-1:0] core_cw;
  logic [hes_pkg::LEN_W-1:0]   core_syn;
  logic                        core_err;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // held high across reset, cleared at the next edge with rst low
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  hes_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // capture the command beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd  <= hes_pkg::cmd_t'(command);
      in_word <= word;
    end
  end

  hes_core u_core (
    .command     (in_cmd),
    .word        (in_word),
    .cfg         (cfg),
    .codeword    (core_cw),
    .syndrome    (core_syn),
    .error_found (core_err)
  );

  // result register, strobed for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      codeword        <= core_cw;
      codeword_length <= cfg.n;
      syndrome        <= core_syn;
      error_found     <= core_err;
    end
  end

endmodule

[rtl/hes_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hes_checker
// port-level checks for the hamming block, bound to the top level
// ----------------------------------------------------------------------------
module hes_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [hes_pkg::CW_BITS-1:0] codeword,
  input logic [hes_pkg::LEN_W-1:0]   syndrome,
  input logic                        error_found
);

  // every accepted beat gives a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !rst) ##1 !rst |=> done)
    else $error("accepted beat produced no result");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without accepted beat");

  a_err_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (error_found == (syndrome != '0)))
    else $error("error flag disagrees with syndrome");

  // results with a nonzero syndrome carry no codeword
  a_check_zero_cw: assert property (@(posedge clk) disable iff (rst)
    (done && (syndrome != '0)) |-> (codeword == '0))
    else $error("nonzero syndrome with nonzero codeword");

endmodule

bind hamming_encode_and_syndrome hes_checker u_hes_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .codeword    (codeword),
  .syndrome    (syndrome),
  .error_found (error_found)
);
